// ===== rtl/ehp_pkg.sv =====
// ethernet header parser package: frame record types, codes and constants
// used by the front and back modules and the top level; no dependencies
`default_nettype none

package ehp_pkg;

    localparam logic [15:0] LLC_LIMIT  = 16'd1500;
    localparam logic [15:0] TYPE_IPV4  = 16'h0800;
    localparam logic [15:0] TYPE_ARP   = 16'h0806;

    localparam logic [7:0]  PROTO_ICMP = 8'd1;
    localparam logic [7:0]  PROTO_TCP  = 8'd6;
    localparam logic [7:0]  PROTO_UDP  = 8'd17;
    localparam logic [7:0]  URG_MASK   = 8'h20;

    localparam logic [7:0]  ETH_BYTES  = 8'd14;
    localparam logic [7:0]  LLC_BYTES  = 8'd17;
    localparam logic [7:0]  ARP_BYTES  = 8'd42;
    localparam logic [7:0]  IPV4_BYTES = 8'd34;
    localparam logic [7:0]  UDP_BYTES  = 8'd8;
    localparam logic [5:0]  TCP_MIN    = 6'd20;
    localparam logic [15:0] SUM_ALL_ONES = 16'hffff;

    localparam logic [1:0]  KIND_LLC   = 2'd0;
    localparam logic [1:0]  KIND_IPV4  = 2'd1;
    localparam logic [1:0]  KIND_ARP   = 2'd2;
    localparam logic [1:0]  KIND_OTHER = 2'd3;

    localparam logic [1:0]  TCLASS_ICMP = 2'd0;
    localparam logic [1:0]  TCLASS_TCP  = 2'd1;
    localparam logic [1:0]  TCLASS_UDP  = 2'd2;
    localparam logic [1:0]  TCLASS_NONE = 2'd3;

    localparam logic [1:0]  LLC_FMT_I  = 2'd0;
    localparam logic [1:0]  LLC_FMT_S  = 2'd1;
    localparam logic [1:0]  LLC_FMT_U  = 2'd2;

    localparam logic [1:0]  CTL_S_BITS = 2'b01;
    localparam logic [1:0]  CTL_U_BITS = 2'b11;

    localparam int unsigned OUT_DATA_W = 80;

    // captured header state of one frame, handed from front to back
    typedef struct packed {
        logic [7:0]  len;
        logic [15:0] type_word;
        logic [5:0]  ip_hl;
        logic [7:0]  proto;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [5:0]  tcp_hl;
        logic [15:0] tcp_sum;
        logic [15:0] addr_sum;
        logic [7:0]  ctl;
        logic        urg;
    } t_frame_rec;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] type_word;
        logic        trunc;
        logic [7:0]  proto;
        logic [5:0]  ip_hl;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [5:0]  tcp_hl;
        logic [15:0] part_sum;
        logic [15:0] tcp_sum;
        logic [7:0]  ctl;
        logic        urg;
    } t_stage_rec;

    typedef struct packed {
        logic [1:0]  frame_kind;
        logic [15:0] type_or_length;
        logic [7:0]  ip_protocol;
        logic [5:0]  ip_header_bytes;
        logic [1:0]  transport_class;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic        tcp_checksum_good;
        logic        tcp_urgent;
        logic [1:0]  llc_format;
        logic [6:0]  llc_code;
        logic        truncated;
    } t_result;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, w};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ehp_front.sv =====
// byte capture front end: counts bytes, latches header fields and runs the
// ones-complement sums; emits one frame record on the last beat; uses ehp_pkg
`default_nettype none

module ehp_front #(
    parameter int unsigned MAX_FRAME_BYTES = 2048
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_valid,
    output logic                    o_ready,
    input  wire  [7:0]              i_byte,
    input  wire                     i_last,
    output logic                    o_rec_valid,
    input  wire                     i_rec_ready,
    output ehp_pkg::t_frame_rec     o_rec
);

    localparam int unsigned PW = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned LW = (PW > 8) ? PW : 8;

    logic [PW-1:0] r_pos,    n_pos;
    logic [15:0]   r_type,   n_type;
    logic [5:0]    r_hl,     n_hl;
    logic [7:0]    r_proto,  n_proto;
    logic [15:0]   r_sp,     n_sp;
    logic [15:0]   r_dp,     n_dp;
    logic [5:0]    r_tcp_hl, n_tcp_hl;
    logic [15:0]   r_sum,    n_sum;
    logic [15:0]   r_addr,   n_addr;
    logic [7:0]    r_pend,   n_pend;
    logic [7:0]    r_ctl,    n_ctl;
    logic          r_urg,    n_urg;

    logic          accept;
    logic          push;
    logic          take;
    logic [6:0]    t0;
    logic [PW-1:0] rel;
    logic [LW-1:0] pos_w;

    assign o_ready     = i_rec_ready;
    assign accept      = i_valid && o_ready;
    assign push        = accept && i_last;
    assign o_rec_valid = push;
    assign take        = r_pos < PW'(MAX_FRAME_BYTES);

    always_comb begin
        n_pos    = r_pos;
        n_type   = r_type;
        n_hl     = r_hl;
        n_proto  = r_proto;
        n_sp     = r_sp;
        n_dp     = r_dp;
        n_tcp_hl = r_tcp_hl;
        n_sum    = r_sum;
        n_addr   = r_addr;
        n_pend   = r_pend;
        n_ctl    = r_ctl;
        n_urg    = r_urg;
        t0       = '0;
        rel      = '0;
        if (take) begin
            if (r_pos == PW'(12)) n_type = {i_byte, 8'h00};
            if (r_pos == PW'(13)) n_type = r_type | {8'h00, i_byte};
            if (r_pos >= PW'(14)) begin
                if (r_type < ehp_pkg::LLC_LIMIT) begin
                    if (r_pos == PW'(16)) n_ctl = i_byte;
                end else if (r_type == ehp_pkg::TYPE_IPV4) begin
                    if (r_pos == PW'(14)) n_hl = {i_byte[3:0], 2'b00};
                    if (r_pos == PW'(23)) n_proto = i_byte;
                    if (!r_pos[0]) begin
                        n_pend = i_byte;
                    end else if (r_pos >= PW'(26) && r_pos <= PW'(33)) begin
                        n_addr = ehp_pkg::oc_add(r_addr, {r_pend, i_byte});
                    end
                    t0 = 7'd14 + {1'b0, n_hl};
                    if (r_pos >= PW'(t0)) begin
                        rel = r_pos - PW'(t0);
                        if (rel == PW'(0))  n_sp = {i_byte, 8'h00};
                        if (rel == PW'(1))  n_sp = r_sp | {8'h00, i_byte};
                        if (rel == PW'(2))  n_dp = {i_byte, 8'h00};
                        if (rel == PW'(3))  n_dp = r_dp | {8'h00, i_byte};
                        if (rel == PW'(12)) n_tcp_hl = {i_byte[7:4], 2'b00};
                        if (rel == PW'(13)) n_urg = |(i_byte & ehp_pkg::URG_MASK);
                        if (rel[0] && (rel < PW'(20) || rel < PW'(n_tcp_hl))) begin
                            n_sum = ehp_pkg::oc_add(r_sum, {r_pend, i_byte});
                        end
                    end
                end
            end
            n_pos = r_pos + PW'(1);
        end
    end

    assign pos_w = LW'(n_pos);

    always_comb begin
        o_rec.len       = (pos_w > LW'(255)) ? 8'hff : pos_w[7:0];
        o_rec.type_word = n_type;
        o_rec.ip_hl     = n_hl;
        o_rec.proto     = n_proto;
        o_rec.src_port  = n_sp;
        o_rec.dst_port  = n_dp;
        o_rec.tcp_hl    = n_tcp_hl;
        o_rec.tcp_sum   = n_sum;
        o_rec.addr_sum  = n_addr;
        o_rec.ctl       = n_ctl;
        o_rec.urg       = n_urg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || push) begin
            r_pos    <= '0;
            r_type   <= '0;
            r_hl     <= '0;
            r_proto  <= '0;
            r_sp     <= '0;
            r_dp     <= '0;
            r_tcp_hl <= '0;
            r_sum    <= '0;
            r_addr   <= '0;
            r_pend   <= '0;
            r_ctl    <= '0;
            r_urg    <= 1'b0;
        end else if (accept) begin
            r_pos    <= n_pos;
            r_type   <= n_type;
            r_hl     <= n_hl;
            r_proto  <= n_proto;
            r_sp     <= n_sp;
            r_dp     <= n_dp;
            r_tcp_hl <= n_tcp_hl;
            r_sum    <= n_sum;
            r_addr   <= n_addr;
            r_pend   <= n_pend;
            r_ctl    <= n_ctl;
            r_urg    <= n_urg;
        end
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(MAX_FRAME_BYTES))
        else $error("byte count past frame limit");

    a_pos_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> r_pos == '0)
        else $error("byte count not cleared after last beat");

    a_hl_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !push && r_pos > PW'(14)) |=> $stable(r_hl))
        else $error("ip header length changed after its byte");

endmodule

`default_nettype wire

// ===== rtl/ehp_queue.sv =====
// short register fifo of frame records between front and back
// generic width; no package dependency
`default_nettype none

module ehp_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    output logic             o_not_full,
    input  wire  [WIDTH-1:0] i_data,
    output logic             o_not_empty,
    input  wire              i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             wr_en;
    logic             rd_en;

    assign o_not_full  = r_count != CW'(DEPTH);
    assign o_not_empty = r_count != '0;
    assign wr_en       = i_push && o_not_full;
    assign rd_en       = i_pop && o_not_empty;
    assign o_data      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (rd_en) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (wr_en && !rd_en) begin
                r_count <= r_count + CW'(1);
            end else if (rd_en && !wr_en) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count overflow");

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_not_full)
        else $error("record pushed into full queue");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && !rd_en) |=> r_count == $past(r_count) + CW'(1))
        else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// ===== rtl/ehp_back.sv =====
// back end: classifies a frame record, checks lengths, completes the tcp
// checksum and formats the summary; two registered stages; uses ehp_pkg
`default_nettype none

module ehp_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  ehp_pkg::t_frame_rec  i_rec,
    output logic                 o_valid,
    input  wire                  i_ready,
    output ehp_pkg::t_result     o_res
);

    ehp_pkg::t_stage_rec r_st, n_st;
    ehp_pkg::t_result    r_res, n_res;
    logic                r_v1;
    logic                r_v2;
    logic                ready1;
    logic                ready2;
    logic [7:0]          ip_end;
    logic [7:0]          tcp_len;
    logic [7:0]          need;
    logic [15:0]         full_sum;

    assign ready2  = !r_v2 || i_ready;
    assign ready1  = !r_v1 || ready2;
    assign o_ready = ready1;
    assign o_valid = r_v2;
    assign o_res   = r_res;

    // stage one: kind, length check, partial checksum
    always_comb begin
        ip_end  = ehp_pkg::ETH_BYTES + {2'b00, i_rec.ip_hl};
        tcp_len = (i_rec.tcp_hl < ehp_pkg::TCP_MIN) ? {2'b00, ehp_pkg::TCP_MIN}
                                                    : {2'b00, i_rec.tcp_hl};
        need    = (ip_end > ehp_pkg::IPV4_BYTES) ? ip_end : ehp_pkg::IPV4_BYTES;
        if (i_rec.proto == ehp_pkg::PROTO_TCP) begin
            if (ip_end + tcp_len > need) need = ip_end + tcp_len;
        end else if (i_rec.proto == ehp_pkg::PROTO_UDP) begin
            if (ip_end + ehp_pkg::UDP_BYTES > need) need = ip_end + ehp_pkg::UDP_BYTES;
        end

        n_st.type_word = i_rec.type_word;
        n_st.proto     = i_rec.proto;
        n_st.ip_hl     = i_rec.ip_hl;
        n_st.src_port  = i_rec.src_port;
        n_st.dst_port  = i_rec.dst_port;
        n_st.tcp_hl    = i_rec.tcp_hl;
        n_st.tcp_sum   = i_rec.tcp_sum;
        n_st.ctl       = i_rec.ctl;
        n_st.urg       = i_rec.urg;
        n_st.part_sum  = ehp_pkg::oc_add(
            ehp_pkg::oc_add(i_rec.addr_sum, {8'h00, ehp_pkg::PROTO_TCP}),
            {10'd0, i_rec.tcp_hl});

        priority if (i_rec.type_word < ehp_pkg::LLC_LIMIT) begin
            n_st.kind = ehp_pkg::KIND_LLC;
        end else if (i_rec.type_word == ehp_pkg::TYPE_IPV4) begin
            n_st.kind = ehp_pkg::KIND_IPV4;
        end else if (i_rec.type_word == ehp_pkg::TYPE_ARP) begin
            n_st.kind = ehp_pkg::KIND_ARP;
        end else begin
            n_st.kind = ehp_pkg::KIND_OTHER;
        end

        unique case (n_st.kind)
            ehp_pkg::KIND_LLC:  n_st.trunc = i_rec.len < ehp_pkg::LLC_BYTES;
            ehp_pkg::KIND_IPV4: n_st.trunc = i_rec.len < need;
            ehp_pkg::KIND_ARP:  n_st.trunc = i_rec.len < ehp_pkg::ARP_BYTES;
            default:            n_st.trunc = 1'b0;
        endcase

        // runt frame
        if (i_rec.len < ehp_pkg::ETH_BYTES) begin
            n_st.kind      = ehp_pkg::KIND_OTHER;
            n_st.type_word = '0;
            n_st.trunc     = 1'b1;
        end
    end

    // stage two: final sum and field formatting
    assign full_sum = ehp_pkg::oc_add(r_st.part_sum, r_st.tcp_sum);

    always_comb begin
        n_res                   = '0;
        n_res.frame_kind        = r_st.kind;
        n_res.type_or_length    = r_st.type_word;
        n_res.transport_class   = ehp_pkg::TCLASS_NONE;
        n_res.truncated         = r_st.trunc;
        if (!r_st.trunc) begin
            if (r_st.kind == ehp_pkg::KIND_LLC) begin
                unique case (r_st.ctl[1:0])
                    ehp_pkg::CTL_S_BITS: begin
                        n_res.llc_format = ehp_pkg::LLC_FMT_S;
                        n_res.llc_code   = {5'd0, r_st.ctl[3:2]};
                    end
                    ehp_pkg::CTL_U_BITS: begin
                        n_res.llc_format = ehp_pkg::LLC_FMT_U;
                        n_res.llc_code   = {2'd0, r_st.ctl[7:5], r_st.ctl[3:2]};
                    end
                    default: begin
                        n_res.llc_format = ehp_pkg::LLC_FMT_I;
                        n_res.llc_code   = r_st.ctl[7:1];
                    end
                endcase
            end else if (r_st.kind == ehp_pkg::KIND_IPV4) begin
                n_res.ip_protocol     = r_st.proto;
                n_res.ip_header_bytes = r_st.ip_hl;
                if (r_st.proto == ehp_pkg::PROTO_ICMP) begin
                    n_res.transport_class = ehp_pkg::TCLASS_ICMP;
                end else if (r_st.proto == ehp_pkg::PROTO_TCP) begin
                    n_res.transport_class   = ehp_pkg::TCLASS_TCP;
                    n_res.source_port       = r_st.src_port;
                    n_res.destination_port  = r_st.dst_port;
                    n_res.tcp_urgent        = r_st.urg;
                    n_res.tcp_checksum_good = (full_sum == ehp_pkg::SUM_ALL_ONES) &&
                                              (r_st.tcp_hl >= ehp_pkg::TCP_MIN);
                end else if (r_st.proto == ehp_pkg::PROTO_UDP) begin
                    n_res.transport_class  = ehp_pkg::TCLASS_UDP;
                    n_res.source_port      = r_st.src_port;
                    n_res.destination_port = r_st.dst_port;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r_st <= n_st;
        end
        if (ready2) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (ready1) r_v1 <= i_valid;
            if (ready2) r_v2 <= r_v1;
        end
    end

    a_trunc_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_res.truncated) |-> (r_res.transport_class == ehp_pkg::TCLASS_NONE &&
            r_res.source_port == '0 && r_res.ip_protocol == '0))
        else $error("truncated summary carries header fields");

    a_good_is_tcp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_res.tcp_checksum_good) |-> r_res.transport_class == ehp_pkg::TCLASS_TCP)
        else $error("checksum flag on a non tcp frame");

    a_llc_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_res.frame_kind != ehp_pkg::KIND_LLC) |-> r_res.llc_code == '0)
        else $error("llc code on a non llc frame");

    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && ready2) |=> r_v2)
        else $error("stage one summary lost");

endmodule

`default_nettype wire

// ===== rtl/ethernet_header_parser_core.sv =====
// Ethernet header parser top level: takes one frame byte per beat (up to one per
// clock, no gaps needed between frames) and gives one summary beat per frame. The
// byte front end updates its counter, field latches and 16-bit ones-complement
// sums on each accepted byte; on the last byte it writes a frame record into a
// two-entry queue, and the back end turns that record into a summary through two
// register stages, the stage record and then the result register. The back end
// drains one record per clock, so back-to-back one-byte frames run at full rate
// while the output is taken; a stalled output fills the queue and then holds off
// the byte input. Bytes past MAX_FRAME_BYTES are ignored.
// depends on ehp_pkg, ehp_front, ehp_queue and ehp_back
`default_nettype none

module ethernet_header_parser_core #(
    parameter int unsigned MAX_FRAME_BYTES = 2048
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // data_byte
    input  wire         s_axis_tlast,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // type_or_length[15:0], ip_protocol[23:16], ip_header_bytes[29:24],
    // transport_class[31:30], source_port[47:32], destination_port[63:48],
    // tcp_checksum_good[64], tcp_urgent[65], llc_format[67:66],
    // llc_code[74:68], truncated[75], zero fill[79:76]
    output logic [ehp_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser    // frame_kind
);

    localparam int unsigned REC_W = $bits(ehp_pkg::t_frame_rec);

    ehp_pkg::t_frame_rec front_rec;
    ehp_pkg::t_frame_rec back_rec;
    ehp_pkg::t_result    res;
    logic                rec_valid;
    logic                q_not_full;
    logic                q_not_empty;
    logic                back_ready;
    logic [REC_W-1:0]    q_out;

    ehp_front #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_rec_valid (rec_valid),
        .i_rec_ready (q_not_full),
        .o_rec       (front_rec)
    );

    ehp_queue #(
        .WIDTH(REC_W),
        .DEPTH(2)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (rec_valid),
        .o_not_full  (q_not_full),
        .i_data      (front_rec),
        .o_not_empty (q_not_empty),
        .i_pop       (back_ready),
        .o_data      (q_out)
    );

    assign back_rec = q_out;

    ehp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_not_empty),
        .o_ready (back_ready),
        .i_rec   (back_rec),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tuser = res.frame_kind;
    assign m_axis_tdata = {4'd0, res.truncated, res.llc_code, res.llc_format,
                           res.tcp_urgent, res.tcp_checksum_good,
                           res.destination_port, res.source_port,
                           res.transport_class, res.ip_header_bytes,
                           res.ip_protocol, res.type_or_length};

endmodule

`default_nettype wire
